>>> design/bpq_pkg.sv
package bpq_pkg;

    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_REPEAT = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [CFG_DATA_BITS-1:0] MIN_REPEAT_RESET = 16'd200;

    // button phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_PRESSED  = 2'd2;
    localparam logic [1:0] PH_LONG     = 2'd3;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] debounce_ticks;
        logic [CFG_DATA_BITS-1:0] long_press_ticks;
        logic [CFG_DATA_BITS-1:0] min_repeat_ticks;
    } bpq_cfg_t;

    typedef struct packed {
        logic short_press;
        logic long_press;
        logic held;
    } lane_flags_t;

endpackage

>>> design/bpq_in_if.sv
interface bpq_in_if #(
    parameter int BUTTON_COUNT = 3
);
    logic                    valid;
    logic                    ready;
    logic [BUTTON_COUNT-1:0] pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

>>> design/bpq_out_if.sv
interface bpq_out_if #(
    parameter int BUTTON_COUNT = 3
);
    logic                    valid;
    logic                    ready;
    logic [BUTTON_COUNT-1:0] short_press_mask;
    logic [BUTTON_COUNT-1:0] long_press_mask;
    logic [BUTTON_COUNT-1:0] held_mask;

    modport source (output valid, output short_press_mask, output long_press_mask,
                    output held_mask, input ready);
    modport sink   (input valid, input short_press_mask, input long_press_mask,
                    input held_mask, output ready);
endinterface

>>> design/bpq_lane.sv
module bpq_lane
    import bpq_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 level,
    input  logic [TIME_BITS-1:0] now,
    input  bpq_cfg_t             cfg,
    output lane_flags_t          flags
);

    logic [1:0]           phase_reg, phase_next;
    logic                 prev_level_reg;
    logic [TIME_BITS-1:0] start_time_reg, start_time_next;
    logic [TIME_BITS-1:0] last_short_reg, last_short_next;

    logic [1:0]           phase_a;
    logic [1:0]           phase_b;
    logic [TIME_BITS-1:0] start_a;
    logic                 short_hit;
    logic                 long_hit;

    // level edges: start or cancel debounce, end a press
    always_comb
    begin
        phase_a         = phase_reg;
        start_a         = start_time_reg;
        last_short_next = last_short_reg;
        short_hit       = 1'b0;
        if (level != prev_level_reg)
        begin
            if (level == 1'b0)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_a = PH_DEBOUNCE;
                    start_a = now;
                end
            end
            else
            begin
                phase_a = PH_IDLE;
                if (phase_reg == PH_PRESSED &&
                    (now - last_short_reg) >= TIME_BITS'(cfg.min_repeat_ticks))
                begin
                    last_short_next = now;
                    short_hit       = 1'b1;
                end
            end
        end
    end

    // debounce expiry: confirm or drop
    always_comb
    begin
        phase_b         = phase_a;
        start_time_next = start_a;
        if (phase_a == PH_DEBOUNCE &&
            (now - start_a) >= TIME_BITS'(cfg.debounce_ticks))
        begin
            if (level == 1'b0)
            begin
                phase_b         = PH_PRESSED;
                start_time_next = now;
            end
            else
            begin
                phase_b = PH_IDLE;
            end
        end
    end

    // long press fires once
    always_comb
    begin
        phase_next = phase_b;
        long_hit   = 1'b0;
        if (phase_b == PH_PRESSED &&
            (now - start_time_next) >= TIME_BITS'(cfg.long_press_ticks))
        begin
            phase_next = PH_LONG;
            long_hit   = 1'b1;
        end
    end

    assign flags.short_press = short_hit;
    assign flags.long_press  = long_hit;
    assign flags.held        = (phase_next == PH_PRESSED) || (phase_next == PH_LONG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            prev_level_reg <= 1'b1;
            start_time_reg <= '0;
            last_short_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            prev_level_reg <= level;
            start_time_reg <= start_time_next;
            last_short_reg <= last_short_next;
        end
    end

endmodule

>>> design/button_press_qualifier_core.sv
// Button press qualifier: debounce, short press and long press detection for
// a row of active-low buttons, one lane per button.
//
// Channels: in_ch carries one millisecond tick per transfer, with pin_levels
// holding the raw level of every button (1 released, 0 pressed). out_ch gives
// exactly one result per tick: short_press_mask, long_press_mask and
// held_mask. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data) for the debounce, long-press and minimum-repeat times in ticks;
// write it only while no tick is in flight.
//
// Latency: a tick's result is valid on out_ch the cycle after its transfer.
// Throughput: one tick per cycle; all lanes update in the same cycle, each
// with three wrap-around subtract-and-compare steps on TIME_BITS values.
//
// Reset clears the tick counter, puts every button in idle with level high,
// zeroes the press and short-press timestamps and loads the default times
// (50, 1000, 200). When out_ch stalls, the output register holds its result
// and in_ch.ready drops, so no tick is taken until the result is drained.
module button_press_qualifier_core
    import bpq_pkg::*;
#(
    parameter int BUTTON_COUNT = 3,
    parameter int TIME_BITS    = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    bpq_in_if.sink                    in_ch,
    bpq_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    bpq_cfg_t             cfg_reg;
    logic [TIME_BITS-1:0] tick_count_reg;

    logic                    out_valid_reg;
    logic [BUTTON_COUNT-1:0] short_mask_reg;
    logic [BUTTON_COUNT-1:0] long_mask_reg;
    logic [BUTTON_COUNT-1:0] held_mask_reg;

    logic                    advance;
    lane_flags_t             lane_flags [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] short_mask_next;
    logic [BUTTON_COUNT-1:0] long_mask_next;
    logic [BUTTON_COUNT-1:0] held_mask_next;

    // take a new tick whenever the output register is empty or being drained
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign advance     = in_ch.valid && in_ch.ready;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= LONG_PRESS_RESET;
            cfg_reg.min_repeat_ticks <= MIN_REPEAT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   cfg_reg.debounce_ticks   <= cfg_data;
                REG_LONG_PRESS: cfg_reg.long_press_ticks <= cfg_data;
                REG_MIN_REPEAT: cfg_reg.min_repeat_ticks <= cfg_data;
                default:        ;
            endcase
        end
    end

    // free-running tick time; advance once per transferred tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
        end
        else if (advance)
        begin
            tick_count_reg <= tick_count_reg + 1'b1;
        end
    end

    // one lane per button, all on the same tick time
    for (genvar i = 0; i < BUTTON_COUNT; i++)
    begin : g_lane
        bpq_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .level   (in_ch.pin_levels[i]),
            .now     (tick_count_reg),
            .cfg     (cfg_reg),
            .flags   (lane_flags[i])
        );
    end

    // merge lane flags into the three result masks
    always_comb
    begin
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            short_mask_next[i] = lane_flags[i].short_press;
            long_mask_next[i]  = lane_flags[i].long_press;
            held_mask_next[i]  = lane_flags[i].held;
        end
    end

    // output register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            short_mask_reg <= short_mask_next;
            long_mask_reg  <= long_mask_next;
            held_mask_reg  <= held_mask_next;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.short_press_mask = short_mask_reg;
    assign out_ch.long_press_mask  = long_mask_reg;
    assign out_ch.held_mask        = held_mask_reg;

endmodule

>>> design/bpq_checker.sv
module bpq_checker #(
    parameter int BUTTON_COUNT = 3
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [BUTTON_COUNT-1:0] short_press_mask,
    input logic [BUTTON_COUNT-1:0] long_press_mask,
    input logic [BUTTON_COUNT-1:0] held_mask
);

    // a stalled result holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(short_press_mask) && $stable(long_press_mask) &&
            $stable(held_mask))
        else $error("stalled result changed");

    // every transferred tick shows a result on the next cycle
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("tick without result");

    // a short press ends the press: no long press and no hold on that button
    a_short_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (short_press_mask & (long_press_mask | held_mask)) == '0)
        else $error("short press overlaps long press or hold");

    // a long press leaves the button held
    a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (long_press_mask & ~held_mask) == '0)
        else $error("long press without hold");

endmodule

bind button_press_qualifier_core bpq_checker #(
    .BUTTON_COUNT (BUTTON_COUNT)
) u_bpq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .short_press_mask (out_ch.short_press_mask),
    .long_press_mask  (out_ch.long_press_mask),
    .held_mask        (out_ch.held_mask)
);

>>> verif/button_press_qualifier_core_tb.sv
module button_press_qualifier_core_tb;
    import bpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES = 3;
    localparam int TBITS = 32;

    // index 3 addresses no register; the block must ignore writes to it
    localparam logic [CFG_INDEX_BITS-1:0] REG_NONE = 2'd3;

    localparam logic [CFG_DATA_BITS-1:0] TICKS_MAX = 16'hFFFF;

    // long receiver hold-off: starts once this many ticks have transferred,
    // lasts this many cycles
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 60;

    typedef struct packed {
        logic [LANES-1:0] short_mask;
        logic [LANES-1:0] long_mask;
        logic [LANES-1:0] held_mask;
    } press_masks_t;

    // one entry of the stimulus script: either a register write or a tick
    typedef struct {
        bit                       write_reg;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [CFG_DATA_BITS-1:0]  reg_value;
        logic [LANES-1:0]          pins;
    } script_step_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_ALTERNATE,
        RX_RARELY
    } rx_pattern_t;

    logic clk;
    logic rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    bpq_in_if  #(.BUTTON_COUNT(LANES)) in_ch ();
    bpq_out_if #(.BUTTON_COUNT(LANES)) out_ch ();

    button_press_qualifier_core #(
        .BUTTON_COUNT(LANES),
        .TIME_BITS   (TBITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    script_step_t pending_steps[$];
    press_masks_t expected_masks[$];
    int           failures       = 0;
    int           ticks_accepted = 0;
    bit           tick_taken     = 1'b0;

    // Predictor state: our own copy of the per-button lanes and the timing
    // registers, advanced once per accepted tick.
    bpq_cfg_t          timing;
    logic [TBITS-1:0]  tick_now;
    logic [1:0]        lane_phase      [LANES];
    logic              lane_level      [LANES];
    logic [TBITS-1:0]  lane_start      [LANES];
    logic [TBITS-1:0]  lane_last_short [LANES];

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_lanes();
        tick_now = '0;
        timing   = '{DEBOUNCE_RESET, LONG_PRESS_RESET, MIN_REPEAT_RESET};
        for (int b = 0; b < LANES; b++)
        begin
            lane_phase[b]      = PH_IDLE;
            lane_level[b]      = 1'b1;
            lane_start[b]      = '0;
            lane_last_short[b] = '0;
        end
    endfunction

    function automatic void load_timing(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_DEBOUNCE:   timing.debounce_ticks   = value;
            REG_LONG_PRESS: timing.long_press_ticks = value;
            REG_MIN_REPEAT: timing.min_repeat_ticks = value;
            default: ;
        endcase
    endfunction

    // Advance every lane by one tick and return the masks the block must give.
    // Time differences are plain TBITS-wide subtractions, so they wrap.
    function automatic press_masks_t qualify_tick(input logic [LANES-1:0] pins);
        press_masks_t masks;
        logic [1:0]   phase;
        logic         level;
        masks = '0;
        for (int b = 0; b < LANES; b++)
        begin
            level = pins[b];
            phase = lane_phase[b];
            if (level != lane_level[b])
            begin
                if (level == 1'b0)
                begin
                    // falling edge: start debounce only from idle
                    if (phase == PH_IDLE)
                    begin
                        phase         = PH_DEBOUNCE;
                        lane_start[b] = tick_now;
                    end
                end
                else if (phase == PH_PRESSED)
                begin
                    // release from pressed: short press, subject to repeat gap
                    phase = PH_IDLE;
                    if (tick_now - lane_last_short[b] >=
                        TBITS'(timing.min_repeat_ticks))
                    begin
                        lane_last_short[b]  = tick_now;
                        masks.short_mask[b] = 1'b1;
                    end
                end
                else
                begin
                    // release cancels debounce or ends a long hold silently
                    phase = PH_IDLE;
                end
            end
            lane_level[b] = level;

            if (phase == PH_DEBOUNCE &&
                tick_now - lane_start[b] >= TBITS'(timing.debounce_ticks))
            begin
                if (level == 1'b0)
                begin
                    phase         = PH_PRESSED;
                    lane_start[b] = tick_now;
                end
                else
                begin
                    phase = PH_IDLE;
                end
            end

            // may chain on the same tick as the confirmation
            if (phase == PH_PRESSED &&
                tick_now - lane_start[b] >= TBITS'(timing.long_press_ticks))
            begin
                phase              = PH_LONG;
                masks.long_mask[b] = 1'b1;
            end

            if (phase == PH_PRESSED || phase == PH_LONG)
            begin
                masks.held_mask[b] = 1'b1;
            end
            lane_phase[b] = phase;
        end
        tick_now = tick_now + 1'b1;
        return masks;
    endfunction

    // ------------------------------------------------------------------
    // Script builders
    // ------------------------------------------------------------------
    task automatic add_tick(input logic [LANES-1:0] pins);
        script_step_t s;
        s.write_reg = 1'b0;
        s.reg_index = REG_DEBOUNCE;
        s.reg_value = '0;
        s.pins      = pins;
        pending_steps.push_back(s);
    endtask

    task automatic add_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
        script_step_t s;
        s.write_reg = 1'b1;
        s.reg_index = idx;
        s.reg_value = value;
        s.pins      = '1;
        pending_steps.push_back(s);
    endtask

    task automatic add_timing(input logic [CFG_DATA_BITS-1:0] deb,
                              input logic [CFG_DATA_BITS-1:0] lng,
                              input logic [CFG_DATA_BITS-1:0] rep);
        add_reg(REG_DEBOUNCE, deb);
        add_reg(REG_LONG_PRESS, lng);
        add_reg(REG_MIN_REPEAT, rep);
    endtask

    // Build realistic button waveforms: each lane holds a level for a run
    // and then flips. Press runs are sized around the debounce and long
    // thresholds (glitch, short press, long press); release runs around the
    // repeat gap. A few ticks are pure noise on all pins.
    task automatic add_press_traffic(input int n_ticks, input int deb,
                                     input int lng, input int rep);
        int               run_left [LANES];
        logic [LANES-1:0] level;
        int               d;
        int               l;
        int               r;
        d     = (deb > 40) ? 40 : deb;
        l     = (lng > 40) ? 40 : lng;
        r     = (rep > 40) ? 40 : rep;
        level = '1;
        for (int b = 0; b < LANES; b++)
        begin
            run_left[b] = $urandom_range(1, 6);
        end
        for (int t = 0; t < n_ticks; t++)
        begin
            for (int b = 0; b < LANES; b++)
            begin
                if (run_left[b] == 0)
                begin
                    level[b] = ~level[b];
                    if (level[b] == 1'b0)
                    begin
                        case ($urandom_range(0, 3))
                            0:       run_left[b] = $urandom_range(1, d + 1);
                            1, 2:    run_left[b] = d + 1 + $urandom_range(0, l);
                            default: run_left[b] = d + l + $urandom_range(1, 8);
                        endcase
                    end
                    else
                    begin
                        run_left[b] = $urandom_range(1, r + 4);
                    end
                end
                run_left[b]--;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                add_tick(LANES'($urandom));
            end
            else
            begin
                add_tick(level);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Input monitor, predictor update and result checker (rising edge)
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        press_masks_t seen;
        press_masks_t want;
        if (!rst_n)
        begin
            clear_lanes();
        end
        else
        begin
            // apply register writes to our copy on the same edge as the block
            if (cfg_we)
            begin
                load_timing(cfg_index, cfg_data);
            end

            // tick transfer: predict its masks and retire it from the script
            if (in_ch.valid && in_ch.ready)
            begin
                expected_masks.push_back(qualify_tick(in_ch.pin_levels));
                if (pending_steps.size() != 0)
                begin
                    void'(pending_steps.pop_front());
                end
                tick_taken = 1'b1;
                ticks_accepted++;
            end

            // result transfer: compare with the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                seen.short_mask = out_ch.short_press_mask;
                seen.long_mask  = out_ch.long_press_mask;
                seen.held_mask  = out_ch.held_mask;
                if (expected_masks.size() == 0)
                begin
                    $error("result transfer with no tick outstanding: %b/%b/%b",
                           seen.short_mask, seen.long_mask, seen.held_mask);
                    failures++;
                end
                else
                begin
                    want = expected_masks.pop_front();
                    if (seen.short_mask !== want.short_mask)
                    begin
                        $error("short_press_mask: expected %b, got %b",
                               want.short_mask, seen.short_mask);
                        failures++;
                    end
                    if (seen.long_mask !== want.long_mask)
                    begin
                        $error("long_press_mask: expected %b, got %b",
                               want.long_mask, seen.long_mask);
                        failures++;
                    end
                    if (seen.held_mask !== want.held_mask)
                    begin
                        $error("held_mask: expected %b, got %b",
                               want.held_mask, seen.held_mask);
                        failures++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tick driver (falling edge): bursts of transfers with random gaps.
    // Register writes wait until every predicted result has drained.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        logic                      next_valid;
        logic [LANES-1:0]          next_pins;
        logic                      next_we;
        logic [CFG_INDEX_BITS-1:0] next_index;
        logic [CFG_DATA_BITS-1:0]  next_data;
        next_valid = 1'b0;
        next_pins  = in_ch.pin_levels;
        next_we    = 1'b0;
        next_index = cfg_index;
        next_data  = cfg_data;
        if (rst_n)
        begin
            if (in_ch.valid && !tick_taken)
            begin
                // hold the offered tick until it transfers
                next_valid = 1'b1;
            end
            else if (pending_steps.size() != 0)
            begin
                if (pending_steps[0].write_reg)
                begin
                    // write only with the block idle
                    if (expected_masks.size() == 0)
                    begin
                        next_we    = 1'b1;
                        next_index = pending_steps[0].reg_index;
                        next_data  = pending_steps[0].reg_value;
                        void'(pending_steps.pop_front());
                    end
                end
                else if (gap_left != 0)
                begin
                    gap_left--;
                end
                else
                begin
                    next_valid = 1'b1;
                    next_pins  = pending_steps[0].pins;
                    if (burst_left <= 1)
                    begin
                        // end of burst: pick the next burst and the gap before it
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
        tick_taken = 1'b0;
        in_ch.valid      <= next_valid;
        in_ch.pin_levels <= next_pins;
        cfg_we           <= next_we;
        cfg_index        <= next_index;
        cfg_data         <= next_data;
    end

    // ------------------------------------------------------------------
    // Result receiver (falling edge): rotating stall patterns, plus one
    // long hold-off that fills the output register and backs up the input.
    // ------------------------------------------------------------------
    rx_pattern_t rx_pattern = RX_ALWAYS;
    int          pattern_left = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          alt_phase    = 1'b0;

    always @(negedge clk)
    begin
        logic next_ready;
        next_ready = 1'b0;
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left--;
            end
            else if (!hold_done && ticks_accepted >= HOLD_OFF_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    rx_pattern   = rx_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 120);
                end
                pattern_left--;
                alt_phase = ~alt_phase;
                case (rx_pattern)
                    RX_ALWAYS:    next_ready = 1'b1;
                    RX_MOSTLY:    next_ready = ($urandom_range(0, 3) != 0);
                    RX_ALTERNATE: next_ready = alt_phase;
                    default:      next_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
        out_ch.ready <= next_ready;
    end

    // ------------------------------------------------------------------
    // Stimulus script, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [CFG_DATA_BITS-1:0] deb;
        logic [CFG_DATA_BITS-1:0] lng;
        logic [CFG_DATA_BITS-1:0] rep;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_DEBOUNCE;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.pin_levels = '1;
        out_ch.ready     = 1'b0;

        // Directed: short debounce and long times, repeat gap longer than
        // the directed run so that early presses after reset are rejected.
        add_timing(16'd1, 16'd4, 16'd20);
        add_reg(REG_NONE, 16'd0);
        add_tick(3'b110);          // button 0 down: debounce
        add_tick(3'b110);          // confirmed
        add_tick(3'b111);          // release too soon after reset: rejected
        add_tick(3'b101);          // button 1 down
        add_tick(3'b111);          // released during debounce: cancel
        repeat (6) add_tick(3'b000);   // all down until the long press fires
        add_tick(3'b111);          // release from long hold: no event

        // Zero debounce and long time: confirm and fire on the press tick.
        add_timing(16'd0, 16'd0, 16'd0);
        add_tick(3'b011);
        add_tick(3'b111);

        // Short presses with no repeat gap, then with one that rejects.
        add_reg(REG_LONG_PRESS, 16'd2);
        add_tick(3'b110);
        add_tick(3'b111);          // accepted
        add_tick(3'b110);
        add_tick(3'b111);          // accepted again
        add_reg(REG_MIN_REPEAT, 16'd5);
        add_tick(3'b110);
        add_tick(3'b111);          // rejected, last short time kept

        // Random rounds: extremes first, then mostly small timings so that
        // presses confirm, repeat and go long within a few dozen ticks.
        add_timing(16'd0, 16'd0, 16'd0);
        add_press_traffic(100, 0, 0, 0);
        add_timing(TICKS_MAX, TICKS_MAX, TICKS_MAX);
        add_press_traffic(40, 8, 8, 8);
        for (int round = 0; round < 10; round++)
        begin
            deb = CFG_DATA_BITS'($urandom_range(0, 6));
            lng = CFG_DATA_BITS'($urandom_range(0, 25));
            rep = CFG_DATA_BITS'($urandom_range(0, 40));
            case ($urandom_range(0, 7))
                0:       deb = TICKS_MAX;
                1:       lng = TICKS_MAX;
                2:       rep = TICKS_MAX;
                default: ;
            endcase
            add_timing(deb, lng, rep);
            add_press_traffic(96, int'(deb), int'(lng), int'(rep));
        end

        // Reset once, then let the driver and receiver run the script.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_steps.size() != 0 || expected_masks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);

        if (failures == 0)
        begin
            $display("button_press_qualifier_core_tb: clean");
        end
        else
        begin
            $display("button_press_qualifier_core_tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of the script.
    initial
    begin
        #2_000_000;
        $display("button_press_qualifier_core_tb: errors");
        $finish;
    end

endmodule

>>> files.f
design/bpq_pkg.sv
design/bpq_in_if.sv
design/bpq_out_if.sv
design/bpq_lane.sv
design/button_press_qualifier_core.sv
design/bpq_checker.sv
verif/button_press_qualifier_core_tb.sv
